// ===== rtl/tle_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, character codes and the microcode table of the line editor.
// Used by tle_sequencer, tle_datapath and terminal_line_editor_core.
package tle_pkg;

    localparam int TLE_LINE_CAPACITY = 32;

    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_DEL = 8'h7F;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;

    typedef logic [3:0] t_upc;

    typedef enum logic [2:0] {
        SRC_RX, SRC_BS, SRC_SP, SRC_CR, SRC_LF, SRC_MEM
    } t_src;

    typedef enum logic [1:0] {
        LAST_NONE, LAST_ONE, LAST_NO_DELIVER, LAST_RD_LAST
    } t_last_sel;

    typedef enum logic [1:0] {
        CNT_HOLD, CNT_STORE_INC, CNT_DEC, CNT_CLR
    } t_cnt_op;

    typedef enum logic [1:0] {
        PTR_HOLD, PTR_CLR, PTR_INC
    } t_ptr_op;

    typedef enum logic [2:0] {
        COND_NONE, COND_ALWAYS, COND_NO_INPUT, COND_ERASE,
        COND_EXP_EOL, COND_NO_DELIVER, COND_NOT_RD_LAST, COND_EMPTY
    } t_cond;

    typedef struct packed {
        logic      take_in;
        logic      emit;
        t_src      src;
        logic      kind;
        logic      end_rd;
        t_last_sel last_sel;
        t_cnt_op   cnt_op;
        t_ptr_op   ptr_op;
        t_cond     cond;
        t_upc      target;
    } t_uword;

    typedef struct packed {
        logic erase;
        logic exp_eol;
        logic no_deliver;
        logic rd_last;
        logic empty;
        logic out_free;
    } t_status;

    localparam t_upc UPC_IDLE       = 4'd0;
    localparam t_upc UPC_DECODE     = 4'd1;
    localparam t_upc UPC_STORE      = 4'd2;
    localparam t_upc UPC_ECHO_SEL   = 4'd3;
    localparam t_upc UPC_ECHO_RX    = 4'd4;
    localparam t_upc UPC_TO_LINE    = 4'd5;
    localparam t_upc UPC_ECHO_CR    = 4'd6;
    localparam t_upc UPC_ECHO_LF    = 4'd7;
    localparam t_upc UPC_LINE_START = 4'd8;
    localparam t_upc UPC_LINE_BYTE  = 4'd9;
    localparam t_upc UPC_LINE_DONE  = 4'd10;
    localparam t_upc UPC_ERASE_CHK  = 4'd11;
    localparam t_upc UPC_ERASE_DEC  = 4'd12;
    localparam t_upc UPC_ERASE_BS1  = 4'd13;
    localparam t_upc UPC_ERASE_SP   = 4'd14;
    localparam t_upc UPC_ERASE_BS2  = 4'd15;

    localparam t_uword UWORD_NOP = '{
        take_in: 1'b0, emit: 1'b0, src: SRC_RX, kind: 1'b0, end_rd: 1'b0,
        last_sel: LAST_NONE, cnt_op: CNT_HOLD, ptr_op: PTR_HOLD,
        cond: COND_NONE, target: UPC_IDLE
    };

    // The control program. Each step either waits on the output register
    // (emit steps) or advances without holding.
    function automatic t_uword ucode(input t_upc pc);
        t_uword w;
        begin
            w = UWORD_NOP;
            unique case (pc)
                UPC_IDLE: begin
                    w.take_in = 1'b1;
                    w.cond    = COND_NO_INPUT;
                    w.target  = UPC_IDLE;
                end
                UPC_DECODE: begin
                    w.cond   = COND_ERASE;
                    w.target = UPC_ERASE_CHK;
                end
                UPC_STORE: begin
                    w.cnt_op = CNT_STORE_INC;
                end
                UPC_ECHO_SEL: begin
                    w.cond   = COND_EXP_EOL;
                    w.target = UPC_ECHO_CR;
                end
                UPC_ECHO_RX: begin
                    w.emit     = 1'b1;
                    w.src      = SRC_RX;
                    w.last_sel = LAST_NO_DELIVER;
                    w.cond     = COND_NO_DELIVER;
                    w.target   = UPC_IDLE;
                end
                UPC_TO_LINE: begin
                    w.cond   = COND_ALWAYS;
                    w.target = UPC_LINE_START;
                end
                UPC_ECHO_CR: begin
                    w.emit = 1'b1;
                    w.src  = SRC_CR;
                end
                UPC_ECHO_LF: begin
                    w.emit     = 1'b1;
                    w.src      = SRC_LF;
                    w.last_sel = LAST_NO_DELIVER;
                    w.cond     = COND_NO_DELIVER;
                    w.target   = UPC_IDLE;
                end
                UPC_LINE_START: begin
                    w.ptr_op = PTR_CLR;
                end
                UPC_LINE_BYTE: begin
                    w.emit     = 1'b1;
                    w.src      = SRC_MEM;
                    w.kind     = 1'b1;
                    w.end_rd   = 1'b1;
                    w.last_sel = LAST_RD_LAST;
                    w.ptr_op   = PTR_INC;
                    w.cond     = COND_NOT_RD_LAST;
                    w.target   = UPC_LINE_BYTE;
                end
                UPC_LINE_DONE: begin
                    w.cnt_op = CNT_CLR;
                    w.cond   = COND_ALWAYS;
                    w.target = UPC_IDLE;
                end
                UPC_ERASE_CHK: begin
                    w.cond   = COND_EMPTY;
                    w.target = UPC_IDLE;
                end
                UPC_ERASE_DEC: begin
                    w.cnt_op = CNT_DEC;
                end
                UPC_ERASE_BS1: begin
                    w.emit = 1'b1;
                    w.src  = SRC_BS;
                end
                UPC_ERASE_SP: begin
                    w.emit = 1'b1;
                    w.src  = SRC_SP;
                end
                UPC_ERASE_BS2: begin
                    w.emit     = 1'b1;
                    w.src      = SRC_BS;
                    w.last_sel = LAST_ONE;
                    w.cond     = COND_ALWAYS;
                    w.target   = UPC_IDLE;
                end
                default: begin
                    w = UWORD_NOP;
                end
            endcase
            return w;
        end
    endfunction

endpackage

// ===== rtl/tle_sequencer.sv =====
`timescale 1ns / 1ps
// Step counter and microcode fetch with conditional jumps.
// Depends on tle_pkg for the control word, status and the program table.
module tle_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  tle_pkg::t_status i_status,
    output tle_pkg::t_uword  o_uword
);
    import tle_pkg::*;

    t_upc   r_upc;
    t_upc   n_upc;
    t_uword w_uword;
    logic   w_advance;
    logic   w_jump;

    assign w_uword   = ucode(r_upc);
    assign o_uword   = w_uword;
    // An emit step holds until the output register can take its result.
    assign w_advance = !w_uword.emit || i_status.out_free;

    always_comb begin
        unique case (w_uword.cond)
            COND_NONE:        w_jump = 1'b0;
            COND_ALWAYS:      w_jump = 1'b1;
            COND_NO_INPUT:    w_jump = !i_in_valid;
            COND_ERASE:       w_jump = i_status.erase;
            COND_EXP_EOL:     w_jump = i_status.exp_eol;
            COND_NO_DELIVER:  w_jump = i_status.no_deliver;
            COND_NOT_RD_LAST: w_jump = !i_status.rd_last;
            COND_EMPTY:       w_jump = i_status.empty;
            default:          w_jump = 1'b0;
        endcase
    end

    always_comb begin
        n_upc = r_upc;
        if (w_advance) begin
            n_upc = w_jump ? w_uword.target : r_upc + t_upc'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UPC_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

// ===== rtl/tle_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: received byte, fill count, line store, read pointer, output register.
// Driven by the control word from tle_sequencer; types from tle_pkg.
module tle_datapath #(
    parameter int LINE_CAPACITY = tle_pkg::TLE_LINE_CAPACITY
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tle_pkg::t_uword  i_uword,
    input  logic             i_in_valid,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic             i_out_ready,
    output tle_pkg::t_status o_status,
    output logic             o_out_valid,
    output logic             o_out_kind,
    output logic [7:0]       o_out_byte,
    output logic             o_line_end,
    output logic             o_last_result
);
    import tle_pkg::*;

    localparam int CW = $clog2(LINE_CAPACITY);

    logic [7:0]    r_rx;
    logic          r_expand;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_rdptr;
    logic [CW-1:0] n_rdptr;
    logic [7:0]    r_line_mem [LINE_CAPACITY];
    logic [7:0]    r_rd_data;
    logic          r_out_valid;
    logic          r_out_kind;
    logic [7:0]    r_out_byte;
    logic          r_line_end;
    logic          r_last;

    logic       w_is_eol;
    logic       w_deliver;
    logic       w_rd_last;
    logic       w_out_free;
    logic       w_load;
    logic       w_last;
    logic [7:0] w_byte;

    assign w_is_eol   = (r_rx == CH_CR) || (r_rx == CH_LF);
    // Checked after the byte is stored, so the count already includes it.
    assign w_deliver  = w_is_eol || (r_count == CW'(LINE_CAPACITY - 1));
    assign w_rd_last  = (r_rdptr + CW'(1)) == r_count;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_load     = i_uword.emit && w_out_free;

    assign o_status.erase      = (r_rx == CH_BS) || (r_rx == CH_DEL);
    assign o_status.exp_eol    = w_is_eol && r_expand;
    assign o_status.no_deliver = !w_deliver;
    assign o_status.rd_last    = w_rd_last;
    assign o_status.empty      = (r_count == '0);
    assign o_status.out_free   = w_out_free;

    always_comb begin
        unique case (i_uword.src)
            SRC_RX:  w_byte = r_rx;
            SRC_BS:  w_byte = CH_BS;
            SRC_SP:  w_byte = CH_SP;
            SRC_CR:  w_byte = CH_CR;
            SRC_LF:  w_byte = CH_LF;
            SRC_MEM: w_byte = r_rd_data;
            default: w_byte = r_rx;
        endcase
    end

    always_comb begin
        unique case (i_uword.last_sel)
            LAST_NONE:       w_last = 1'b0;
            LAST_ONE:        w_last = 1'b1;
            LAST_NO_DELIVER: w_last = !w_deliver;
            LAST_RD_LAST:    w_last = w_rd_last;
            default:         w_last = 1'b0;
        endcase
    end

    always_comb begin
        unique case (i_uword.cnt_op)
            CNT_HOLD:      n_count = r_count;
            CNT_STORE_INC: n_count = r_count + CW'(1);
            CNT_DEC:       n_count = r_count - CW'(1);
            CNT_CLR:       n_count = '0;
            default:       n_count = r_count;
        endcase
    end

    // The read address runs one step ahead so that each line byte is
    // ready in the cycle its emit step starts.
    always_comb begin
        unique case (i_uword.ptr_op)
            PTR_HOLD: n_rdptr = r_rdptr;
            PTR_CLR:  n_rdptr = '0;
            PTR_INC:  n_rdptr = w_load ? r_rdptr + CW'(1) : r_rdptr;
            default:  n_rdptr = r_rdptr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_uword.cnt_op == CNT_STORE_INC) begin
            r_line_mem[r_count] <= r_rx;
        end
        r_rd_data <= r_line_mem[n_rdptr];
    end

    always_ff @(posedge i_clk) begin
        if (i_uword.take_in && i_in_valid) begin
            r_rx <= i_rx_byte;
        end
        if (w_load) begin
            r_out_kind <= i_uword.kind;
            r_out_byte <= w_byte;
            r_line_end <= i_uword.end_rd && w_rd_last;
            r_last     <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expand    <= 1'b0;
            r_count     <= '0;
            r_rdptr     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_expand <= i_cfg_wdata;
            end
            r_count <= n_count;
            r_rdptr <= n_rdptr;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_kind    = r_out_kind;
    assign o_out_byte    = r_out_byte;
    assign o_line_end    = r_line_end;
    assign o_last_result = r_last;

endmodule

// ===== rtl/terminal_line_editor_core.sv =====
`timescale 1ns / 1ps
// Top level of the terminal line editor: sequencer plus datapath.
// Depends on tle_pkg, tle_sequencer and tle_datapath.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready, i_rx_byte) takes one received
//   byte per item. Output channel (o_out_valid / i_out_ready) delivers the
//   results: echo bytes (o_out_kind 0) first, then, on CR, LF or when the
//   line holds LINE_CAPACITY - 1 bytes, the stored line bytes (o_out_kind 1)
//   with o_line_end on the final one. o_last_result marks the last result of
//   each input item; an erase on an empty line produces no result at all.
//   i_cfg_we / i_cfg_wdata write the newline expansion bit (CR or LF echoed
//   as CR LF); write it only while the block is idle.
// Timing:
//   One item is handled at a time. A plain byte is echoed through the output
//   register, an erase gives three echoes, and a line goes out at one line
//   byte per cycle while the receiver keeps up, set by the single read port
//   of the line store. The next item is accepted once the sequencer is back
//   at its idle step.
// Reset clears the fill count, the read pointer, the expansion bit and the output valid flag.
// While the receiver stalls, the current emit step holds and nothing is lost.
module terminal_line_editor_core #(
    parameter int LINE_CAPACITY = tle_pkg::TLE_LINE_CAPACITY
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_out_kind,
    output logic [7:0] o_out_byte,
    output logic       o_line_end,
    output logic       o_last_result
);
    import tle_pkg::*;

    t_uword  w_uword;
    t_status w_status;

    assign o_in_ready = w_uword.take_in;

    tle_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_uword    (w_uword)
    );

    tle_datapath #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_uword       (w_uword),
        .i_in_valid    (i_in_valid),
        .i_rx_byte     (i_rx_byte),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_out_ready   (i_out_ready),
        .o_status      (w_status),
        .o_out_valid   (o_out_valid),
        .o_out_kind    (o_out_kind),
        .o_out_byte    (o_out_byte),
        .o_line_end    (o_line_end),
        .o_last_result (o_last_result)
    );

endmodule

// ===== dv/terminal_line_editor_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for terminal_line_editor_core: echo, erase and line delivery.
// Depends on tle_pkg and the RTL of the line editor; a scoreboard class predicts every result.
module terminal_line_editor_core_tb;
    import tle_pkg::*;

    localparam int CAP             = TLE_LINE_CAPACITY;
    localparam int SETTLE_CYCLES   = 20;
    localparam int STALL_LIMIT     = 2000;
    localparam int ITEMS_PER_PHASE = 130;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       line_end;
        logic       last;
    } t_out_item;

    class echo_line_scoreboard;
        logic [7:0]  line_buf [CAP];
        int unsigned fill;
        bit          expand;
        t_out_item   batch[$];
        t_out_item   expected_out[$];
        int          errors;

        function new();
            fill   = 0;
            expand = 1'b0;
            errors = 0;
        endfunction

        function void add_out(logic kind, logic [7:0] data, logic line_end);
            t_out_item r;
            r.kind     = kind;
            r.data     = data;
            r.line_end = line_end;
            r.last     = 1'b0;
            batch.push_back(r);
        endfunction

        // Works out the results of one accepted byte and queues them.
        function int note_rx_byte(logic [7:0] ch);
            bit is_eol;
            batch.delete();
            if (ch == CH_BS || ch == CH_DEL) begin
                if (fill == 0) begin
                    return 0;
                end
                fill--;
                add_out(1'b0, CH_BS, 1'b0);
                add_out(1'b0, CH_SP, 1'b0);
                add_out(1'b0, CH_BS, 1'b0);
            end else begin
                is_eol = (ch == CH_CR || ch == CH_LF);
                if (is_eol && expand) begin
                    add_out(1'b0, CH_CR, 1'b0);
                    add_out(1'b0, CH_LF, 1'b0);
                end else begin
                    add_out(1'b0, ch, 1'b0);
                end
                line_buf[fill] = ch;
                fill++;
                // A line of CAP - 1 bytes goes out without any end byte.
                if (is_eol || fill >= CAP - 1) begin
                    for (int i = 0; i < fill; i++) begin
                        add_out(1'b1, line_buf[i], (i + 1 == fill));
                    end
                    fill = 0;
                end
            end
            batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i]) begin
                expected_out.push_back(batch[i]);
            end
            return batch.size();
        endfunction

        function void report(string field, logic [7:0] exp_v, logic [7:0] got_v);
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, got_v);
            errors++;
        endfunction

        function void check_out_item(t_out_item got);
            t_out_item exp_r;
            if (expected_out.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %b byte %h",
                         $time, got.kind, got.data);
                errors++;
                return;
            end
            exp_r = expected_out.pop_front();
            if (got.kind !== exp_r.kind)
                report("out_kind", 8'(exp_r.kind), 8'(got.kind));
            if (got.data !== exp_r.data)
                report("out_byte", exp_r.data, got.data);
            if (got.line_end !== exp_r.line_end)
                report("line_end", 8'(exp_r.line_end), 8'(got.line_end));
            if (got.last !== exp_r.last)
                report("last_result", 8'(exp_r.last), 8'(got.last));
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] rx_byte;
    logic       cfg_we;
    logic       cfg_wdata;
    logic       out_valid;
    logic       out_ready;
    logic       out_kind;
    logic [7:0] out_byte;
    logic       line_end;
    logic       last_result;

    echo_line_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int items_done;
    int stall_cycles = 0;

    // Directed bytes with expansion off, then with expansion on.
    logic [7:0] dir_plain [12] = '{CH_BS, CH_DEL, 8'h00, 8'hFF, CH_BS, 8'h41, CH_DEL,
                                   8'h7E, 8'h80, CH_CR, CH_LF, 8'h55};
    logic [7:0] dir_expand [8] = '{CH_LF, 8'h31, CH_CR, 8'h01, 8'hFE, CH_BS, CH_DEL, CH_BS};

    terminal_line_editor_core #(
        .LINE_CAPACITY(CAP)
    ) i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_rx_byte    (rx_byte),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_out_kind   (out_kind),
        .o_out_byte   (out_byte),
        .o_line_end   (line_end),
        .o_last_result(last_result)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            sb.check_out_item({out_kind, out_byte, line_end, last_result});
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(255));
        end while (b == CH_BS || b == CH_DEL || b == CH_CR || b == CH_LF);
        return b;
    endfunction

    function automatic logic [7:0] erase_code();
        return $urandom_range(1) ? CH_BS : CH_DEL;
    endfunction

    task automatic send_byte(input logic [7:0] ch);
        @(negedge clk);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do begin
                @(negedge clk);
            end while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        rx_byte  <= ch;
        do begin
            @(posedge clk);
        end while (!in_ready);
        if (sb.note_rx_byte(ch) != 0) items_done++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_out.size() != 0) @(negedge clk);
    endtask

    // An erase on an empty line gives no result, so after the drain the task
    // waits out a settle period before the register changes.
    task automatic write_expand(input bit v);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.expand = v;
    endtask

    task automatic send_line(input bit fill_up);
        int pick;
        pick = fill_up ? 0 : $urandom_range(99);
        if (pick < 15) begin
            // Keep typing until the line goes out for being full.
            do begin
                if (!fill_up && $urandom_range(9) == 0) send_byte(erase_code());
                else send_byte(plain_byte());
            end while (sb.fill != 0);
        end else if (pick < 75) begin
            repeat ($urandom_range(12)) begin
                if ($urandom_range(7) == 0) send_byte(erase_code());
                else send_byte(plain_byte());
            end
            send_byte($urandom_range(1) ? CH_CR : CH_LF);
        end else if (pick < 88) begin
            repeat ($urandom_range(1, 6)) send_byte(erase_code());
        end else begin
            repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic run_phase(input int s_pct, input int r_pct, input bit expand_v);
        write_expand(expand_v);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        items_done    = 0;
        send_line(1'b1);
        while (items_done < ITEMS_PER_PHASE) begin
            if ($urandom_range(11) == 0) wait_drained();
            send_line(1'b0);
        end
    endtask

    initial begin
        sb            = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        rx_byte       = 8'h00;
        cfg_we        = 1'b0;
        cfg_wdata     = 1'b0;
        out_ready     = 1'b0;
        send_idle_pct = 12;
        recv_idle_pct = 74;
        items_done    = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        write_expand(1'b0);
        foreach (dir_plain[i]) send_byte(dir_plain[i]);
        write_expand(1'b1);
        foreach (dir_expand[i]) send_byte(dir_expand[i]);

        run_phase(12, 74, 1'b1);
        run_phase(74, 12, 1'b0);
        run_phase(0, 0, 1'b1);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tle_pkg.sv
rtl/tle_sequencer.sv
rtl/tle_datapath.sv
rtl/terminal_line_editor_core.sv
dv/terminal_line_editor_core_tb.sv
